// ===== hw/rtl/tbk_pkg.sv =====
// ----------------------------------------------------------------------------
// tbk_pkg: shared types and constants of the periodic timer bank
// Table size, action and result codes, and the table request/response words.
// ----------------------------------------------------------------------------
package tbk_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int EXP_W = $clog2(MAX_RESULTS);
  localparam int SLOT_CMP_W = 8;

  localparam int IVL_W  = 31;
  localparam int TIME_W = 32;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CREATE  = 3'd1;
  localparam logic [2:0] ACT_DELETE  = 3'd2;
  localparam logic [2:0] ACT_SET_EN  = 3'd3;
  localparam logic [2:0] ACT_SET_IVL = 3'd4;

  localparam logic [1:0] KIND_CREATED   = 2'd0;
  localparam logic [1:0] KIND_EXPIRED   = 2'd1;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd2;
  localparam logic [1:0] KIND_FULL      = 2'd3;

  typedef struct packed {
    logic              set_valid;
    logic              clr_valid;
    logic              wr_enable;
    logic              wr_interval;
    logic              wr_start;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  look_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic              enable;
    logic [IVL_W-1:0]  interval;
    logic [TIME_W-1:0] now;
  } tbl_req_t;

  typedef struct packed {
    logic              valid;
    logic              enabled;
    logic [IVL_W-1:0]  interval;
    logic [TIME_W-1:0] start_time;
  } tbl_rsp_t;

endpackage

// ===== hw/rtl/periodic_timer_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_bank: table of periodic millisecond timers
// Command-driven timer table with a slot-by-slot tick scan.
// ----------------------------------------------------------------------------
// Usage:
//   Drive action, timer_slot, interval_value, enable_bit and now_time and
//   raise start; the word is taken at an edge where busy is low. For a
//   defined action busy then stays high until the command is finished.
//   Results leave on result_kind / result_slot / last_of_run, each valid for
//   exactly one cycle while result_strobe is high. The receiver cannot stall
//   the block; it must take every strobed word. last_of_run marks the final
//   result of a command.
//   Command steps (table size 16):
//     tick       : one slot is fetched per cycle and fed through the shared
//                  add/compare unit, then the compare stage drains and the
//                  run flushes. An expiry is held until the next one or the
//                  flush so the final one can carry last_of_run. The scan
//                  also ends early once 16 expiries are found.
//     create     : one valid flag checked per cycle, up to the table end.
//     delete, set enable, set interval : handled in the command state.
//   A create or not-found result is registered from the cycle that decides
//   it and appears as busy drops.
//   Reset (rst, synchronous) clears all valid flags, so the table is empty;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_timer_bank (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [3:0]  timer_slot,
  input  logic [30:0] interval_value,
  input  logic        enable_bit,
  input  logic [31:0] now_time,
  output logic        result_strobe,
  output logic [1:0]  result_kind,
  output logic [3:0]  result_slot,
  output logic        last_of_run
);

  localparam int IdxW   = tbk_pkg::IDX_W;
  localparam int CntW   = tbk_pkg::CNT_W;
  localparam int ExpW   = tbk_pkg::EXP_W;
  localparam int CmpW   = tbk_pkg::SLOT_CMP_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_TICK   = 5'b00010,
    ST_CREATE = 5'b00100,
    ST_CMD    = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_t;

  state_t st;

  // Command word held for the whole run
  logic [2:0]                 action_r;
  logic [3:0]                 slot_r;
  logic [30:0]                interval_r;
  logic                       enable_r;
  logic [31:0]                now_r;

  // Scan counter, compare stage and held expiry
  logic [CntW-1:0]            cnt;
  logic                       chk_valid;
  logic                       chk_live;
  logic [IdxW-1:0]            chk_slot;
  logic                       pend_valid;
  logic [IdxW-1:0]            pend_slot;
  logic [ExpW-1:0]            exp_cnt;

  tbk_pkg::tbl_req_t          req;
  tbk_pkg::tbl_rsp_t          rsp;

  logic                       expired;
  logic                       hit;
  logic                       cnt_in_range;
  logic                       slot_ok;
  logic                       free_found;
  logic                       cmd_ok;
  logic                       at_limit;

  tbk_table u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shared add/compare unit: one slot per cycle during a tick
  tbk_due u_due (
    .start_time (rsp.start_time),
    .interval   (rsp.interval),
    .now        (now_r),
    .expired    (expired)
  );

  assign busy = (st != ST_IDLE);

  assign cnt_in_range = (cnt < CntW'(tbk_pkg::NUM_TIMERS));
  assign hit          = (st == ST_TICK) && chk_valid && chk_live && expired;
  assign at_limit     = (exp_cnt == ExpW'(tbk_pkg::MAX_RESULTS - 1));
  assign free_found   = (st == ST_CREATE) && cnt_in_range && !rsp.valid;
  // Slots past the table end are never found
  assign slot_ok      = (CmpW'(slot_r) < CmpW'(tbk_pkg::NUM_TIMERS)) && rsp.valid;
  assign cmd_ok       = (st == ST_CMD) && slot_ok;

  // Table request: flag lookup follows the command slot or the scan counter
  always_comb begin
    req.look_addr   = (st == ST_CMD) ? IdxW'(slot_r) : cnt[IdxW-1:0];
    req.rd_addr     = cnt[IdxW-1:0];
    case (st)
      ST_TICK:   req.wr_addr = chk_slot;
      ST_CREATE: req.wr_addr = cnt[IdxW-1:0];
      default:   req.wr_addr = IdxW'(slot_r);
    endcase
    req.set_valid   = free_found;
    req.clr_valid   = cmd_ok && (action_r == tbk_pkg::ACT_DELETE);
    req.wr_enable   = free_found || (cmd_ok && (action_r == tbk_pkg::ACT_SET_EN));
    req.wr_interval = free_found || (cmd_ok && (action_r == tbk_pkg::ACT_SET_IVL));
    req.wr_start    = free_found || hit;
    req.enable      = enable_r;
    req.interval    = interval_r;
    req.now         = now_r;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      result_strobe <= 1'b0;
      chk_valid     <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (start) begin
            action_r   <= action;
            slot_r     <= timer_slot;
            interval_r <= interval_value;
            enable_r   <= enable_bit;
            now_r      <= now_time;
            cnt        <= '0;
            chk_valid  <= 1'b0;
            pend_valid <= 1'b0;
            exp_cnt    <= '0;
            case (action)
              tbk_pkg::ACT_TICK:    st <= ST_TICK;
              tbk_pkg::ACT_CREATE:  st <= ST_CREATE;
              tbk_pkg::ACT_DELETE,
              tbk_pkg::ACT_SET_EN,
              tbk_pkg::ACT_SET_IVL: st <= ST_CMD;
              default:              st <= ST_IDLE;
            endcase
          end
        end
        ST_TICK: begin
          // Emit the held expiry once a newer one shows it was not the last
          if (hit) begin
            if (pend_valid) begin
              result_strobe <= 1'b1;
              result_kind   <= tbk_pkg::KIND_EXPIRED;
              result_slot   <= 4'(pend_slot);
              last_of_run   <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_slot  <= chk_slot;
            exp_cnt    <= exp_cnt + 1'b1;
          end
          if (hit && at_limit) begin
            // Result limit reached: drop the fetch in flight
            chk_valid <= 1'b0;
            st        <= ST_FLUSH;
          end else if (cnt_in_range) begin
            chk_valid <= 1'b1;
            chk_slot  <= cnt[IdxW-1:0];
            chk_live  <= rsp.valid && rsp.enabled;
            cnt       <= cnt + 1'b1;
          end else begin
            chk_valid <= 1'b0;
            if (!chk_valid) begin
              st <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (pend_valid) begin
            result_strobe <= 1'b1;
            result_kind   <= tbk_pkg::KIND_EXPIRED;
            result_slot   <= 4'(pend_slot);
            last_of_run   <= 1'b1;
          end
          pend_valid <= 1'b0;
          st         <= ST_IDLE;
        end
        ST_CREATE: begin
          if (!cnt_in_range) begin
            result_strobe <= 1'b1;
            result_kind   <= tbk_pkg::KIND_FULL;
            result_slot   <= 4'd0;
            last_of_run   <= 1'b1;
            st            <= ST_IDLE;
          end else if (!rsp.valid) begin
            result_strobe <= 1'b1;
            result_kind   <= tbk_pkg::KIND_CREATED;
            result_slot   <= 4'(cnt[IdxW-1:0]);
            last_of_run   <= 1'b1;
            st            <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_CMD: begin
          if (!slot_ok) begin
            result_strobe <= 1'b1;
            result_kind   <= tbk_pkg::KIND_NOT_FOUND;
            result_slot   <= 4'd0;
            last_of_run   <= 1'b1;
          end
          st <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // No expiry may be left over once the block is idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> !pend_valid)
    else $error("held expiry left while idle");

  // Only an expiry can be followed by more results of the same run
  a_not_last_is_expiry: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_of_run) |-> (result_kind == tbk_pkg::KIND_EXPIRED))
    else $error("non-final result of a kind other than expired");

  // The flush step always closes the run
  a_flush_closes: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FLUSH) |=> (st == ST_IDLE))
    else $error("flush did not return to idle");

  // A result with the last mark leaves the block idle
  a_last_when_done: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_of_run) |-> (st == ST_IDLE))
    else $error("final result while still busy");

endmodule

// ===== hw/rtl/tbk_due.sv =====
// ----------------------------------------------------------------------------
// tbk_due: shared expiry check
// One 32-bit wrapping add of start and interval, compared against now.
// ----------------------------------------------------------------------------
module tbk_due (
  input  logic [tbk_pkg::TIME_W-1:0] start_time,
  input  logic [tbk_pkg::IVL_W-1:0]  interval,
  input  logic [tbk_pkg::TIME_W-1:0] now,
  output logic                       expired
);

  logic [tbk_pkg::TIME_W-1:0] due;

  assign due     = start_time + {1'b0, interval};
  assign expired = due < now;

endmodule

// ===== hw/rtl/tbk_table.sv =====
// ----------------------------------------------------------------------------
// tbk_table: timer slot storage
// Valid and enable flags in flops; interval and start time in memories
// with one write port and one registered read port each.
// ----------------------------------------------------------------------------
module tbk_table (
  input  logic              clk,
  input  logic              rst,
  input  tbk_pkg::tbl_req_t req,
  output tbk_pkg::tbl_rsp_t rsp
);

  logic [tbk_pkg::NUM_TIMERS-1:0] valid;
  logic [tbk_pkg::NUM_TIMERS-1:0] enabled;
  logic [tbk_pkg::IVL_W-1:0]      ivl_mem   [tbk_pkg::NUM_TIMERS];
  logic [tbk_pkg::TIME_W-1:0]     start_mem [tbk_pkg::NUM_TIMERS];
  logic [tbk_pkg::IVL_W-1:0]      rd_interval;
  logic [tbk_pkg::TIME_W-1:0]     rd_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (req.set_valid) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.clr_valid) begin
        valid[req.wr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_enable) begin
      enabled[req.wr_addr] <= req.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_interval) begin
      ivl_mem[req.wr_addr] <= req.interval;
    end
    rd_interval <= ivl_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.wr_start) begin
      start_mem[req.wr_addr] <= req.now;
    end
    rd_start <= start_mem[req.rd_addr];
  end

  assign rsp.valid      = valid[req.look_addr];
  assign rsp.enabled    = enabled[req.look_addr];
  assign rsp.interval   = rd_interval;
  assign rsp.start_time = rd_start;

endmodule
